// ===== design/fpt_pkg.sv =====
// Package for the fan PWM and tachometer controller.
// Holds the state codes, the register indexes and shared payload types.
`timescale 1ns / 1ps

package fpt_pkg;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_STARTING  = 3'd1;
    localparam logic [2:0] ST_RUNNING   = 3'd2;
    localparam logic [2:0] ST_START_ERR = 3'd3;
    localparam logic [2:0] ST_RUN_ERR   = 3'd4;

    localparam logic [2:0] REG_MIN_DUTY   = 3'd0;
    localparam logic [2:0] REG_MAX_DUTY   = 3'd1;
    localparam logic [2:0] REG_PHASE_THR  = 3'd2;
    localparam logic [2:0] REG_PHASE_MODE = 3'd3;
    localparam logic [2:0] REG_MIN_RPM    = 3'd4;
    localparam logic [2:0] REG_WINDOW     = 3'd5;
    localparam logic [2:0] REG_SKIP_TACH  = 3'd6;

    localparam logic [1:0] PM_NONE     = 2'd0;
    localparam logic [1:0] PM_TRIANGLE = 2'd1;
    localparam logic [1:0] PM_RANDOM   = 2'd2;

    typedef struct packed {
        logic       tach_level;
        logic [7:0] requested_duty;
        logic [7:0] random_byte;
    } t_fan_in;

    typedef struct packed {
        logic        fan_drive;
        logic        tach_edge;
        logic [15:0] rpm;
        logic        rpm_ready;
        logic [2:0]  ctrl_state;
        logic [6:0]  applied_duty;
        logic        rpm_ok;
    } t_fan_out;

endpackage

// ===== design/fpt_if.sv =====
// Valid/ready channel interface carrying one payload.
// The payload type is given by the parameter T.
`timescale 1ns / 1ps

interface fpt_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/fan_pwm_tach_controller.sv =====
// Fan PWM controller with tach speed measurement, built on one shared
// divider/multiplier datapath run by a small sequencer. Depends on fpt_pkg and fpt_if.
// Sequence: a taken tick passes WN1, WN2 (skipped with the tach ignored), FSM and OUT,
// which raises the response; a random phase move adds PH1-PH3, a duty reload to a value
// from 2 to the phase threshold adds two 7-step divisions, a window end with on-time adds
// WN3 and the 48-step serial divider; the input is not ready until the response is taken.
// Reset: synchronous active low; loads the register defaults and clears the control state only.
`timescale 1ns / 1ps

module fan_pwm_tach_controller
    import fpt_pkg::*;
#(
    parameter int START_TIMEOUT    = 2000,
    parameter int START_EDGE_COUNT = 4,
    parameter int RPM_SETTLE_TICKS = 5000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpt_if.sink         i_req,
    fpt_if.source       o_rsp,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PH1  = 4'd1;
    localparam logic [3:0] S_PH2  = 4'd2;
    localparam logic [3:0] S_PH3  = 4'd3;
    localparam logic [3:0] S_WN1  = 4'd4;
    localparam logic [3:0] S_WN2  = 4'd5;
    localparam logic [3:0] S_WN3  = 4'd6;
    localparam logic [3:0] S_FSM  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    localparam logic [1:0] DR_STEPS = 2'd0;
    localparam logic [1:0] DR_PSTEP = 2'd1;
    localparam logic [1:0] DR_EDGE  = 2'd3;

    logic [6:0]  r_min_duty, r_max_duty, r_phase_thr;
    logic [1:0]  r_phase_mode;
    logic [15:0] r_min_rpm, r_window;
    logic        r_skip;

    logic [3:0]  r_seq;
    logic [6:0]  r_period, r_active, r_pending;
    logic [7:0]  r_phase, r_step;
    logic [6:0]  r_plimit;
    logic        r_last_tach;
    logic [15:0] r_wcount, r_on_ticks, r_speed, r_state_ticks;
    logic [31:0] r_edges;
    logic        r_ready_flag;
    logic [2:0]  r_mode;
    logic [7:0]  r_start_edges;

    t_fan_in     r_in;
    t_fan_out    r_out;
    logic        r_drive, r_edge;
    logic signed [8:0] r_on;

    logic [47:0] r_num, r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic [1:0]  r_dreason;
    logic [47:0] r_prod;

    logic [48:0] w_trial;
    assign w_trial = {r_rem, r_num[47]} - {17'd0, r_den};

    function automatic logic [6:0] f_cmd(input logic [15:0] v, input logic [6:0] mn,
                                         input logic [6:0] mx);
        logic [15:0] t;
        t = v;
        if (t != 16'd0 && t < {9'd0, mn}) t = {9'd0, mn};
        if (t > {9'd0, mx}) t = {9'd0, mx};
        return t[6:0];
    endfunction

    logic w_speed_ok;
    assign w_speed_ok = !(r_in.requested_duty != 8'd0 && r_speed < r_min_rpm);

    assign i_req.ready = (r_seq == S_IDLE) && !o_rsp.valid;
    assign o_rsp.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_duty <= 7'd0; r_max_duty <= 7'd50; r_phase_thr <= 7'd0;
            r_phase_mode <= PM_RANDOM; r_min_rpm <= 16'd0; r_window <= 16'd1000;
            r_skip <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MIN_DUTY:   r_min_duty   <= i_cfg_data[6:0];
                REG_MAX_DUTY:   r_max_duty   <= i_cfg_data[6:0];
                REG_PHASE_THR:  r_phase_thr  <= i_cfg_data[6:0];
                REG_PHASE_MODE: r_phase_mode <= i_cfg_data[1:0];
                REG_MIN_RPM:    r_min_rpm    <= i_cfg_data;
                REG_WINDOW:     r_window     <= i_cfg_data;
                REG_SKIP_TACH:  r_skip       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [9:0] on_v;
        logic [6:0]  pc;
        logic [7:0]  ph;
        logic [15:0] st;
        logic [7:0]  se;
        logic        e;
        logic [3:0]  n_seq;
        logic [15:0] rq;
        if (!i_rst_n) begin
            r_seq <= S_IDLE; r_period <= '0; r_active <= '0; r_pending <= '0;
            r_phase <= '0; r_step <= '0; r_plimit <= '0; r_last_tach <= 1'b0;
            r_wcount <= '0; r_on_ticks <= '0; r_speed <= '0; r_state_ticks <= '0;
            r_edges <= '0; r_ready_flag <= 1'b0; r_mode <= ST_IDLE;
            r_start_edges <= '0; o_rsp.valid <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready) o_rsp.valid <= 1'b0;
            unique case (r_seq)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_in <= i_req.data;
                        on_v = $signed({3'd0, r_period}) - $signed({2'd0, r_phase});
                        if (on_v >= $signed({3'd0, r_active}))
                            on_v = on_v - $signed({3'd0, r_max_duty});
                        r_on <= on_v[8:0];
                        r_drive <= ({1'b0, r_period} >= r_phase) &&
                                   ({2'd0, r_period} < {1'b0, r_phase} + {2'd0, r_active});
                        pc = r_period + 7'd1;
                        n_seq = S_WN1;
                        if (pc >= r_max_duty) begin
                            r_period <= 7'd0;
                            if (r_active != r_pending) begin
                                r_active <= r_pending;
                                r_phase  <= 8'd0;
                                r_plimit <= (r_max_duty > r_pending) ?
                                            r_max_duty - r_pending : 7'd0;
                                r_step <= 8'd0;
                                if (r_pending > 7'd1 && r_pending <= r_phase_thr) begin
                                    r_num <= {r_max_duty, 41'd0};
                                    r_den <= {25'd0, r_pending};
                                    r_rem <= '0; r_cnt <= 6'd7;
                                    r_dreason <= DR_STEPS;
                                    n_seq = S_DIV;
                                end
                            end else if (r_step != 8'd0) begin
                                if (r_phase_mode == PM_NONE) begin
                                    r_phase <= 8'd0;
                                end else if (r_phase_mode == PM_TRIANGLE) begin
                                    ph = r_phase + r_step;
                                    if ($signed(ph) >= $signed({1'b0, r_plimit})) begin
                                        r_step <= -r_step; r_phase <= {1'b0, r_plimit};
                                    end else if ($signed(ph) < 0) begin
                                        r_step <= -r_step; r_phase <= 8'd0;
                                    end else begin
                                        r_phase <= ph;
                                    end
                                end else if (r_phase_mode == PM_RANDOM) begin
                                    n_seq = S_PH1;
                                end
                            end
                        end else begin
                            r_period <= pc;
                        end
                        r_seq <= n_seq;
                    end
                end
                S_PH1: begin
                    r_prod <= {33'd0, 15'({8'd0, r_plimit} * {7'd0, r_in.random_byte})};
                    r_seq <= S_PH2;
                end
                S_PH2: begin
                    // Exact division by 255 for any product below 2^15.
                    rq = r_prod[15:0] + {8'd0, r_prod[15:8]} + 16'd1;
                    r_phase <= rq[15:8];
                    r_seq <= S_PH3;
                end
                S_PH3: begin
                    r_seq <= S_WN1;
                end
                S_WN1: begin
                    if (r_skip) begin
                        r_edge <= 1'b0; r_seq <= S_FSM;
                    end else begin
                        e = (r_in.tach_level != r_last_tach) && (r_on >= 9'sd2);
                        r_edge <= e;
                        r_last_tach <= r_in.tach_level;
                        if (e) r_edges <= r_edges + 32'd1;
                        r_wcount <= r_wcount + 16'd1;
                        r_seq <= S_WN2;
                    end
                end
                S_WN2: begin
                    if (r_wcount >= r_window) begin
                        if (r_on_ticks != 16'd0) begin
                            r_prod <= r_edges * r_window;
                            r_seq <= S_WN3;
                        end else begin
                            r_prod <= {16'd0, r_edges};
                            r_seq <= S_DIV;
                            r_cnt <= 6'd0;
                            r_dreason <= DR_EDGE;
                            r_num <= {16'd0, r_edges};
                        end
                    end else begin
                        if (!r_on[8] && r_on_ticks != 16'hFFFF)
                            r_on_ticks <= r_on_ticks + 16'd1;
                        r_seq <= S_FSM;
                    end
                end
                S_WN3: begin
                    r_num <= r_prod; r_den <= {16'd0, r_on_ticks};
                    r_rem <= '0; r_cnt <= 6'd48;
                    r_dreason <= DR_EDGE; r_seq <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt != 6'd0) begin
                        if (!w_trial[48]) begin
                            r_rem <= w_trial[47:0];
                            r_num <= {r_num[46:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[46:0], r_num[47]};
                            r_num <= {r_num[46:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 6'd1;
                    end else begin
                        unique case (r_dreason)
                            DR_STEPS: begin
                                r_den <= (r_num[6:0] < 7'd3) ? 32'd3 : {25'd0, r_num[6:0]};
                                r_num <= {r_plimit, 41'd0};
                                r_rem <= '0; r_cnt <= 6'd7;
                                r_dreason <= DR_PSTEP;
                            end
                            DR_PSTEP: begin
                                r_step <= {1'b0, r_num[6:0]};
                                r_seq <= S_WN1;
                            end
                            default: begin
                                if (r_num[47:16] != 32'd0) begin
                                    r_speed <= 16'hFFFF;
                                end else begin
                                    r_speed <= ((({18'd0, r_speed} + 34'(r_num[15:0]) * 34'd45)
                                                >> 2) > 34'd65535) ? 16'hFFFF :
                                               16'((({18'd0, r_speed}
                                                + 34'(r_num[15:0]) * 34'd45) >> 2));
                                end
                                r_edges <= '0; r_wcount <= '0; r_on_ticks <= '0;
                                r_ready_flag <= 1'b1;
                                r_seq <= S_FSM;
                            end
                        endcase
                    end
                end
                S_FSM: begin
                    st = r_state_ticks; se = r_start_edges;
                    unique case (r_mode)
                        ST_IDLE: begin
                            if (r_in.requested_duty != 8'd0) begin
                                r_mode <= ST_STARTING;
                                r_start_edges <= 8'd0; r_state_ticks <= 16'd0;
                            end else begin
                                r_pending <= 7'd0;
                            end
                        end
                        ST_STARTING: begin
                            if (r_in.requested_duty == 8'd0) begin
                                r_mode <= ST_IDLE;
                            end else begin
                                if (st != 16'hFFFF) st = st + 16'd1;
                                if ({16'd0, st} > START_TIMEOUT && !r_skip) begin
                                    r_state_ticks <= st;
                                    r_mode <= ST_START_ERR;
                                end else begin
                                    r_pending <= f_cmd({9'd0, r_max_duty},
                                                       r_min_duty, r_max_duty);
                                    if (r_edge && se != 8'hFF) se = se + 8'd1;
                                    r_start_edges <= se;
                                    if ({24'd0, se} >= START_EDGE_COUNT) begin
                                        r_mode <= ST_RUNNING;
                                        r_state_ticks <= 16'd0;
                                    end else begin
                                        r_state_ticks <= st;
                                    end
                                end
                            end
                        end
                        ST_RUNNING: begin
                            if (r_in.requested_duty == 8'd0) begin
                                r_mode <= ST_IDLE;
                            end else begin
                                r_pending <= f_cmd({8'd0, r_in.requested_duty},
                                                   r_min_duty, r_max_duty);
                                if ({16'd0, st} < RPM_SETTLE_TICKS)
                                    r_state_ticks <= st + 16'd1;
                                else if (!w_speed_ok && !r_skip)
                                    r_mode <= ST_RUN_ERR;
                            end
                        end
                        default: begin
                            if (r_in.requested_duty == 8'd0) begin
                                r_mode <= ST_IDLE;
                            end else begin
                                r_pending <= f_cmd({8'd0, r_in.requested_duty},
                                                   r_min_duty, r_max_duty);
                                if (w_speed_ok) r_mode <= ST_RUNNING;
                            end
                        end
                    endcase
                    r_seq <= S_OUT;
                end
                S_OUT: begin
                    r_out.fan_drive    <= r_drive;
                    r_out.tach_edge    <= r_edge;
                    r_out.rpm          <= r_speed;
                    r_out.rpm_ready    <= r_ready_flag;
                    r_out.ctrl_state   <= r_mode;
                    r_out.applied_duty <= r_pending;
                    r_out.rpm_ok       <= w_speed_ok;
                    o_rsp.valid <= 1'b1;
                    r_seq <= S_IDLE;
                end
                default: r_seq <= S_IDLE;
            endcase
        end
    end

endmodule
